>>> sv/xoodoo_pkg.sv
// shared types, constants and round function of the xoodoo permutation core
`timescale 1ns / 1ps

package xoodoo_pkg;

    localparam int LANE_COUNT  = 12;
    localparam int ROUND_TOTAL = 12;
    localparam int LANE_W      = 32;
    localparam int IDX_W       = 4;
    localparam int RC_IDX_W    = 4;

    typedef logic [LANE_COUNT-1:0][LANE_W-1:0] lanes_t;

    typedef enum logic [2:0] {
        ACT_READ      = 3'd0,
        ACT_XOR       = 3'd1,
        ACT_OVERWRITE = 3'd2,
        ACT_EXTRACT   = 3'd3,
        ACT_CLEAR     = 3'd4,
        ACT_PERMUTE   = 3'd5
    } action_t;

    localparam logic [RC_IDX_W-1:0] RC_IDX_LAST = RC_IDX_W'(ROUND_TOTAL - 1);

    typedef struct packed {
        logic                exec_item;
        logic                round_en;
        logic                round_last;
        logic [RC_IDX_W-1:0] rc_index;
    } xoodoo_cmd_t;

    function automatic logic [LANE_W-1:0] rc_lookup(input logic [RC_IDX_W-1:0] i);
        logic [LANE_W-1:0] rc;
        case (i)
            4'd0:    rc = 32'h0000_0058;
            4'd1:    rc = 32'h0000_0038;
            4'd2:    rc = 32'h0000_03C0;
            4'd3:    rc = 32'h0000_00D0;
            4'd4:    rc = 32'h0000_0120;
            4'd5:    rc = 32'h0000_0014;
            4'd6:    rc = 32'h0000_0060;
            4'd7:    rc = 32'h0000_002C;
            4'd8:    rc = 32'h0000_0380;
            4'd9:    rc = 32'h0000_00F0;
            4'd10:   rc = 32'h0000_01A0;
            4'd11:   rc = 32'h0000_0012;
            default: rc = '0;
        endcase
        return rc;
    endfunction

    function automatic logic [LANE_W-1:0] rotl(input logic [LANE_W-1:0] v, input int n);
        return (v << n) | (v >> (LANE_W - n));
    endfunction

    function automatic lanes_t xoodoo_round(input lanes_t a, input logic [LANE_W-1:0] rc);
        logic [3:0][LANE_W-1:0] p;
        logic [3:0][LANE_W-1:0] e;
        lanes_t t;
        lanes_t b;
        lanes_t c;
        lanes_t r;
        // theta
        for (int x = 0; x < 4; x++)
        begin
            p[x] = a[x] ^ a[4+x] ^ a[8+x];
        end
        for (int x = 0; x < 4; x++)
        begin
            e[x] = rotl(p[(x+3)%4], 5) ^ rotl(p[(x+3)%4], 14);
        end
        for (int x = 0; x < LANE_COUNT; x++)
        begin
            t[x] = a[x] ^ e[x%4];
        end
        // rho-west
        for (int x = 0; x < 4; x++)
        begin
            b[x]   = t[x];
            b[4+x] = t[4+((x+3)%4)];
            b[8+x] = rotl(t[8+x], 11);
        end
        // iota
        b[0] = b[0] ^ rc;
        // chi
        for (int x = 0; x < 4; x++)
        begin
            c[x]   = b[x]   ^ (~b[4+x] & b[8+x]);
            c[4+x] = b[4+x] ^ (~b[8+x] & b[x]);
            c[8+x] = b[8+x] ^ (~b[x]   & b[4+x]);
        end
        // rho-east
        for (int x = 0; x < 4; x++)
        begin
            r[x]   = c[x];
            r[4+x] = rotl(c[4+x], 1);
            r[8+x] = rotl(c[8+((x+2)%4)], 8);
        end
        return r;
    endfunction

endpackage

>>> sv/xoodoo_ctrl.sv
// controller: handshakes, round sequencing and the round count register
`timescale 1ns / 1ps

module xoodoo_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [2:0]            action,
    output logic                  result_valid,
    input  logic                  result_ready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output xoodoo_pkg::xoodoo_cmd_t cmd
);
    import xoodoo_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [RC_IDX_W-1:0]   rc_idx_reg;
    logic [RC_IDX_W-1:0]   rc_idx_next;
    logic [3:0]            round_count_reg;
    logic [3:0]            round_count_next;
    logic [3:0]            rounds_eff;
    logic                  accept;
    logic                  start_run;
    logic                  reg_sel;

    assign reg_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {28'd0, round_count_reg} : '0;

    assign rounds_eff = (round_count_reg > 4'(ROUND_TOTAL)) ? 4'(ROUND_TOTAL)
                                                            : round_count_reg;

    assign item_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign accept       = item_valid && item_ready;
    assign start_run    = accept && (action == ACT_PERMUTE) && (rounds_eff != 4'd0);

    always_comb
    begin
        cmd.exec_item  = accept && !start_run;
        cmd.round_en   = (state_reg == ST_RUN);
        cmd.round_last = (state_reg == ST_RUN) && (rc_idx_reg == RC_IDX_LAST);
        cmd.rc_index   = rc_idx_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        rc_idx_next      = rc_idx_reg;
        round_count_next = round_count_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            round_count_next = pwdata[3:0];
        end
        if (result_valid && result_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (start_run)
                begin
                    state_next  = ST_RUN;
                    rc_idx_next = RC_IDX_W'(ROUND_TOTAL) - rounds_eff;
                end
                else if (accept)
                begin
                    out_valid_next = 1'b1;
                end
            end
            ST_RUN:
            begin
                if (rc_idx_reg == RC_IDX_LAST)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
                else
                begin
                    rc_idx_next = rc_idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            rc_idx_reg      <= '0;
            round_count_reg <= 4'(ROUND_TOTAL);
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            rc_idx_reg      <= rc_idx_next;
            round_count_reg <= round_count_next;
        end
    end

endmodule

>>> sv/xoodoo_dp.sv
// datapath: lane state, lane actions, round logic and result register
`timescale 1ns / 1ps

module xoodoo_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  xoodoo_pkg::xoodoo_cmd_t cmd,
    input  logic [2:0]              action,
    input  logic [3:0]              lane_index,
    input  logic [3:0]              byte_enable,
    input  logic [31:0]             word_in,
    output logic [31:0]             lane_out
);
    import xoodoo_pkg::*;

    lanes_t              lanes_reg;
    lanes_t              lanes_next;
    lanes_t              round_lanes;
    logic [IDX_W-1:0]    idx_reg;
    logic [LANE_W-1:0]   lane_out_reg;
    logic [LANE_W-1:0]   lane_out_next;
    logic [LANE_W-1:0]   mask;
    logic [LANE_W-1:0]   data_m;
    logic [LANE_W-1:0]   lane_sel;
    logic [LANE_W-1:0]   item_lane;
    logic [LANE_W-1:0]   item_result;
    logic                lane_valid;
    logic                idx_valid;

    assign mask   = {{8{byte_enable[3]}}, {8{byte_enable[2]}},
                     {8{byte_enable[1]}}, {8{byte_enable[0]}}};
    assign data_m = word_in & mask;

    assign lane_valid = (lane_index < IDX_W'(LANE_COUNT));
    assign idx_valid  = (idx_reg < IDX_W'(LANE_COUNT));
    assign lane_sel   = lane_valid ? lanes_reg[lane_index] : '0;

    assign round_lanes = xoodoo_round(lanes_reg, rc_lookup(cmd.rc_index));

    always_comb
    begin
        lanes_next    = lanes_reg;
        lane_out_next = lane_out_reg;
        item_lane     = lane_sel;
        item_result   = lane_sel;
        if (cmd.exec_item)
        begin
            case (action)
                ACT_XOR:
                begin
                    item_lane   = lane_sel ^ data_m;
                    item_result = item_lane;
                    if (lane_valid)
                    begin
                        lanes_next[lane_index] = item_lane;
                    end
                end
                ACT_OVERWRITE:
                begin
                    item_lane   = (lane_sel & ~mask) | data_m;
                    item_result = item_lane;
                    if (lane_valid)
                    begin
                        lanes_next[lane_index] = item_lane;
                    end
                end
                ACT_EXTRACT:
                begin
                    item_result = lane_sel ^ data_m;
                end
                ACT_CLEAR:
                begin
                    lanes_next  = '0;
                    item_result = '0;
                end
                default:
                begin
                    item_result = lane_sel;
                end
            endcase
            lane_out_next = lane_valid ? item_result : '0;
        end
        else if (cmd.round_en)
        begin
            lanes_next = round_lanes;
            if (cmd.round_last)
            begin
                lane_out_next = idx_valid ? round_lanes[idx_reg] : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_reg <= '0;
        end
        else
        begin
            lanes_reg <= lanes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_out_reg <= lane_out_next;
        if (cmd.exec_item || !cmd.round_en)
        begin
            idx_reg <= lane_index;
        end
    end

    assign lane_out = lane_out_reg;

endmodule

>>> sv/xoodoo_permutation_core.sv
// top level of the xoodoo-384 permutation core with lane access
`timescale 1ns / 1ps

// usage:
// item channel (item_valid/item_ready) carries one beat per action: action,
// lane_index, byte_enable and word_in; result channel (result_valid/
// result_ready) returns exactly one beat with lane_out for every item.
// for lane read, xor, overwrite, extract-and-add, clear and zero-round permute,
// lane_out is registered and valid the cycle after accept.
// a permute runs one round per cycle through a single round unit, so it
// runs round_count rounds (1 to 12) before its result beat appears, and
// item_ready stays low meanwhile.
// throughput: one lane access per cycle while the receiver keeps up.
// a new item is taken while a result is being taken in the same cycle; if
// the receiver stalls, the result is held and item_ready drops.
// round_count sits at apb address 0 and must be written only while idle
// (not enforced); values above 12 run 12 rounds, zero makes permute a plain read.
// reset clears all lanes and sets round_count to 12; no clearing pass.

module xoodoo_permutation_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [2:0]  action,
    input  logic [3:0]  lane_index,
    input  logic [3:0]  byte_enable,
    input  logic [31:0] word_in,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] lane_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import xoodoo_pkg::*;

    xoodoo_cmd_t cmd;

    xoodoo_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .cmd          (cmd)
    );

    xoodoo_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .lane_index  (lane_index),
        .byte_enable (byte_enable),
        .word_in     (word_in),
        .lane_out    (lane_out)
    );

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the xoodoo permutation core: lane access, permute and round count
`timescale 1ns / 1ps

module tb_top;

    import xoodoo_pkg::*;

    localparam logic [2:0] ACT_RSVD_A  = 3'd6;
    localparam logic [2:0] ACT_RSVD_B  = 3'd7;
    localparam logic [2:0] ROUNDS_ADDR = 3'd0;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 110;
    localparam int DIR_ROWS    = 25;

    localparam logic [31:0] ROUND_CONST [12] = '{
        32'h0058, 32'h0038, 32'h03C0, 32'h00D0, 32'h0120, 32'h0014,
        32'h0060, 32'h002C, 32'h0380, 32'h00F0, 32'h01A0, 32'h0012
    };

    typedef struct packed {
        logic [2:0]  act;
        logic [3:0]  idx;
        logic [3:0]  be;
        logic [31:0] word;
        logic        known;
        logic [31:0] want;
    } lane_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [2:0]  action = ACT_READ;
    logic [3:0]  lane_index = 4'd0;
    logic [3:0]  byte_enable = 4'd0;
    logic [31:0] word_in = 32'd0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [31:0] lane_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    logic [31:0] lane_state [12];
    logic [3:0]  round_cfg;
    logic [31:0] lane_expect_q [$];
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;

    // directed rows: typed expectation where obvious, otherwise predicted
    lane_beat_t dir_rows [DIR_ROWS] = '{
        '{ACT_READ,      4'd0,  4'hF, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ACT_READ,      4'd11, 4'hF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{ACT_OVERWRITE, 4'd0,  4'hF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{ACT_OVERWRITE, 4'd11, 4'h5, 32'hFFFF_FFFF, 1'b1, 32'h00FF_00FF},
        '{ACT_XOR,       4'd11, 4'hF, 32'hFFFF_FFFF, 1'b1, 32'hFF00_FF00},
        '{ACT_XOR,       4'd3,  4'h0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{ACT_OVERWRITE, 4'd3,  4'h0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{ACT_EXTRACT,   4'd11, 4'hF, 32'hFFFF_FFFF, 1'b1, 32'h00FF_00FF},
        '{ACT_EXTRACT,   4'd0,  4'h0, 32'h1234_5678, 1'b1, 32'hFFFF_FFFF},
        '{ACT_READ,      4'd11, 4'h0, 32'h0000_0000, 1'b1, 32'hFF00_FF00},
        '{ACT_OVERWRITE, 4'd12, 4'hF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{ACT_XOR,       4'd15, 4'hF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{ACT_EXTRACT,   4'd15, 4'hF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{ACT_READ,      4'd13, 4'hF, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ACT_RSVD_A,    4'd0,  4'hF, 32'h0000_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{ACT_RSVD_B,    4'd11, 4'hF, 32'hFFFF_FFFF, 1'b1, 32'hFF00_FF00},
        '{ACT_READ,      4'd0,  4'h0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{ACT_PERMUTE,   4'd0,  4'h0, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ACT_PERMUTE,   4'd15, 4'h0, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ACT_READ,      4'd5,  4'h0, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ACT_OVERWRITE, 4'd6,  4'hA, 32'hA5A5_A5A5, 1'b0, 32'h0000_0000},
        '{ACT_CLEAR,     4'd4,  4'hF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{ACT_READ,      4'd7,  4'h0, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ACT_PERMUTE,   4'd1,  4'hF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{ACT_CLEAR,     4'd15, 4'h0, 32'h0000_0000, 1'b1, 32'h0000_0000}
    };

    xoodoo_permutation_core dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void mix_round(input logic [31:0] rc);
        logic [31:0] col_par [4];
        logic [31:0] eff [4];
        logic [31:0] b [12];
        logic [31:0] a0;
        logic [31:0] a1;
        logic [31:0] a2;
        int x;
        for (x = 0; x < 4; x++)
            col_par[x] = lane_state[x] ^ lane_state[4+x] ^ lane_state[8+x];
        for (x = 0; x < 4; x++)
            eff[x] = rot_left(col_par[(x+3)%4], 5) ^ rot_left(col_par[(x+3)%4], 14);
        for (x = 0; x < 12; x++)
            lane_state[x] = lane_state[x] ^ eff[x%4];
        for (x = 0; x < 4; x++)
        begin
            b[x]   = lane_state[x];
            b[4+x] = lane_state[4+((x+3)%4)];
            b[8+x] = rot_left(lane_state[8+x], 11);
        end
        b[0] = b[0] ^ rc;
        for (x = 0; x < 4; x++)
        begin
            a0 = b[x];
            a1 = b[4+x];
            a2 = b[8+x];
            b[x]   = a0 ^ (~a1 & a2);
            b[4+x] = a1 ^ (~a2 & a0);
            b[8+x] = a2 ^ (~a0 & a1);
        end
        for (x = 0; x < 4; x++)
        begin
            lane_state[x]   = b[x];
            lane_state[4+x] = rot_left(b[4+x], 1);
            lane_state[8+x] = rot_left(b[8+((x+2)%4)], 8);
        end
    endfunction

    // applies one beat to the lane model and returns the lane it reports
    function automatic logic [31:0] predict_lane(input lane_beat_t bt);
        logic [31:0] mask;
        logic [31:0] res;
        bit          in_range;
        int          n;
        int          r;
        mask = {{8{bt.be[3]}}, {8{bt.be[2]}}, {8{bt.be[1]}}, {8{bt.be[0]}}};
        in_range = bt.idx < LANE_COUNT;
        res = '0;
        case (bt.act)
            ACT_XOR:
                if (in_range)
                    lane_state[bt.idx] = lane_state[bt.idx] ^ (bt.word & mask);
            ACT_OVERWRITE:
                if (in_range)
                    lane_state[bt.idx] = (lane_state[bt.idx] & ~mask) | (bt.word & mask);
            ACT_CLEAR:
                for (r = 0; r < 12; r++)
                    lane_state[r] = '0;
            ACT_PERMUTE:
            begin
                n = (round_cfg > 4'd12) ? 12 : int'(round_cfg);
                for (r = 12 - n; r < 12; r++)
                    mix_round(ROUND_CONST[r]);
            end
            default:
                ;
        endcase
        if (in_range)
        begin
            res = lane_state[bt.idx];
            if (bt.act == ACT_EXTRACT)
                res = res ^ (bt.word & mask);
        end
        return res;
    endfunction

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 70)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic lane_beat_t random_beat();
        lane_beat_t bt;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 18)
            bt.act = ACT_READ;
        else if (roll < 36)
            bt.act = ACT_XOR;
        else if (roll < 54)
            bt.act = ACT_OVERWRITE;
        else if (roll < 70)
            bt.act = ACT_EXTRACT;
        else if (roll < 73)
            bt.act = ACT_CLEAR;
        else if (roll < 94)
            bt.act = ACT_PERMUTE;
        else if (roll < 97)
            bt.act = ACT_RSVD_A;
        else
            bt.act = ACT_RSVD_B;
        if ($urandom_range(0, 99) < 92)
            bt.idx = 4'($urandom_range(0, 11));
        else
            bt.idx = 4'($urandom_range(12, 15));
        bt.be = 4'($urandom_range(0, 15));
        roll = $urandom_range(0, 99);
        if (roll < 85)
            bt.word = $urandom;
        else if (roll < 90)
            bt.word = 32'h0;
        else if (roll < 95)
            bt.word = 32'hFFFF_FFFF;
        else
            bt.word = 32'h1 << $urandom_range(0, 31);
        bt.known = 1'b0;
        bt.want = '0;
        return bt;
    endfunction

    task automatic drain_results();
        while (lane_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // one beat on the item channel, then an optional gap or full drain
    task automatic issue_beat(input lane_beat_t bt, input bit may_drain);
        logic [31:0] model_val;
        int gap;
        item_valid  <= 1'b1;
        action      <= bt.act;
        lane_index  <= bt.idx;
        byte_enable <= bt.be;
        word_in     <= bt.word;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        model_val = predict_lane(bt);
        lane_expect_q.push_back(bt.known ? bt.want : model_val);
        gap = idle_len();
        if (may_drain && $urandom_range(0, 99) == 0)
        begin
            item_valid <= 1'b0;
            drain_results();
        end
        else if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_rounds(input logic [3:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROUNDS_ADDR;
        pwdata  <= {28'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        round_cfg = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            stall_left = idle_len();
            result_ready <= (stall_left == 0);
        end
        else
            result_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && result_valid && result_ready)
        begin
            if (lane_expect_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result beat: lane_out=%h", lane_out);
            end
            else
            begin
                want = lane_expect_q.pop_front();
                if (lane_out !== want)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("lane_out mismatch: expected %h, got %h", want, lane_out);
                end
            end
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [3:0] rounds_plan [9];
        int ph;
        int i;
        for (i = 0; i < 12; i++)
            lane_state[i] = '0;
        round_cfg = 4'd12;
        rounds_plan = '{4'd1, 4'd12, 4'd0, 4'd15, 4'd13,
                        4'($urandom_range(2, 11)), 4'($urandom_range(0, 15)), 4'd7, 4'd12};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < DIR_ROWS; i++)
            issue_beat(dir_rows[i], 1'b0);
        for (ph = 0; ph < 9; ph++)
        begin
            item_valid <= 1'b0;
            drain_results();
            write_rounds(rounds_plan[ph]);
            calm = (ph % 3 == 2);
            for (i = 0; i < PHASE_ITEMS; i++)
                issue_beat(random_beat(), 1'b1);
        end
        item_valid <= 1'b0;
        drain_results();
        repeat (20) @(posedge clk);
        if (fail_cnt == 0 && lane_expect_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
